/* src/hvc_pkg.sv */
package hvc_pkg;

	localparam int MAX_DIM = 32;
	localparam int DIM_W   = $clog2(MAX_DIM);
	localparam int ADDR_W  = 3 * DIM_W;
	localparam int DEPTH   = 1 << ADDR_W;

	localparam int CELL_W  = 8;
	localparam int COORD_W = 8;
	localparam int CFG_W   = 6;
	localparam int IDX_W   = 2;
	localparam int CMP_W   = 10;
	localparam int NBR_W   = 3;

	localparam logic [CMP_W-1:0] MAX_DIM_C = CMP_W'(MAX_DIM);

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_TEST  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [IDX_W-1:0] REG_SIZE_X = 2'd0;
	localparam logic [IDX_W-1:0] REG_SIZE_Y = 2'd1;
	localparam logic [IDX_W-1:0] REG_SIZE_Z = 2'd2;
	localparam logic [IDX_W-1:0] REG_CULL   = 2'd3;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	localparam logic [NBR_W-1:0] NBR_FIRST = 3'd0;
	localparam logic [NBR_W-1:0] NBR_LAST  = 3'd5;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [COORD_W-1:0] x_coord;
		logic [COORD_W-1:0] y_coord;
		logic [COORD_W-1:0] z_coord;
		logic [CELL_W-1:0]  color_index;
	} in_item_t;

	typedef struct packed {
		logic [COORD_W-1:0] out_x;
		logic [COORD_W-1:0] out_y;
		logic [COORD_W-1:0] out_z;
		logic [CELL_W-1:0]  out_color;
		logic               kept;
		logic               out_of_range;
	} out_item_t;

	// neighbor step: bits [2:1] pick the axis, bit 0 set means +1
	typedef struct packed {
		logic [DIM_W-1:0] x;
		logic [DIM_W-1:0] y;
		logic [DIM_W-1:0] z;
		logic [NBR_W-1:0] step;
	} nbr_req_t;

	function automatic logic [CMP_W-1:0] eff_size(input logic [CFG_W-1:0] s);
		logic [CMP_W-1:0] ext;
		ext = CMP_W'(s);
		return (ext > MAX_DIM_C) ? MAX_DIM_C : ext;
	endfunction

endpackage

/* src/hvc_ram.sv */
module hvc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

/* src/hvc_nbr_unit.sv */
module hvc_nbr_unit
	import hvc_pkg::*;
(
	input  nbr_req_t          req,
	output logic [ADDR_W-1:0] addr
);

	logic [DIM_W-1:0] sel;
	logic [DIM_W-1:0] delta;
	logic [DIM_W-1:0] moved;

	always_comb begin
		case (req.step[2:1])
			AXIS_X:  sel = req.x;
			AXIS_Y:  sel = req.y;
			default: sel = req.z;
		endcase
		// all ones is minus one
		delta = req.step[0] ? DIM_W'(1) : '1;
		moved = sel + delta;
		case (req.step[2:1])
			AXIS_X:  addr = {moved, req.y, req.z};
			AXIS_Y:  addr = {req.x, moved, req.z};
			default: addr = {req.x, req.y, moved};
		endcase
	end

endmodule

/* src/hidden_voxel_cull_top.sv */
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_stall   in_item  (opcode, x, y, z, color)
// out      output     out_valid / out_stall out_item (x, y, z, color, kept, range)
// cfg      input      cfg_write_en          cfg_index, cfg_data
//
// All work goes through one single-port grid RAM with registered read.
// Write: EXEC. Test: EXEC, DONE or six neighbor READs, LAST, WB if hidden, DONE.
// Clear item and reset: a pass over 32768 cells, one cell a cycle, no input taken.
// A finished test waits in the output register; the next item is taken meanwhile.
module hidden_voxel_cull_top
	import hvc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_item_t         in_item,
	output logic             out_valid,
	input  logic             out_stall,
	output out_item_t        out_item,
	input  logic             cfg_write_en,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_EXEC  = 7'b0000100,
		ST_READ  = 7'b0001000,
		ST_LAST  = 7'b0010000,
		ST_WB    = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	state_t            state_q;
	in_item_t          item_q;
	out_item_t         out_item_q;
	logic              out_valid_q;
	logic [CFG_W-1:0]  size_x_q, size_y_q, size_z_q;
	logic              cull_q;
	logic [ADDR_W-1:0] clr_ptr_q;
	logic [NBR_W-1:0]  nbr_q;
	logic              rd_pend_s1;
	logic              all_q;
	logic              inside_q;
	logic              hidden_q;

	logic [CMP_W-1:0]  sx, sy, sz, xe, ye, ze;
	logic              in_model, interior, cand;
	logic [ADDR_W-1:0] own_addr, nbr_addr;
	nbr_req_t          nbr_req;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_addr;
	logic [CELL_W-1:0] ram_wdata, ram_rdata;
	logic              nz, hit, out_take, out_load;

	always_comb begin
		sx = eff_size(size_x_q);
		sy = eff_size(size_y_q);
		sz = eff_size(size_z_q);
		xe = CMP_W'(item_q.x_coord);
		ye = CMP_W'(item_q.y_coord);
		ze = CMP_W'(item_q.z_coord);
		in_model = (xe < sx) && (ye < sy) && (ze < sz);
		interior = (xe != '0) && (xe + CMP_W'(1) < sx) &&
			(ye != '0) && (ye + CMP_W'(1) < sy) &&
			(ze != '0) && (ze + CMP_W'(1) < sz);
		cand = in_model && cull_q && interior;
	end

	assign own_addr = {item_q.x_coord[DIM_W-1:0], item_q.y_coord[DIM_W-1:0],
		item_q.z_coord[DIM_W-1:0]};

	assign nbr_req = '{x: item_q.x_coord[DIM_W-1:0], y: item_q.y_coord[DIM_W-1:0],
		z: item_q.z_coord[DIM_W-1:0], step: nbr_q};

	hvc_nbr_unit u_nbr (
		.req  (nbr_req),
		.addr (nbr_addr)
	);

	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = own_addr;
		ram_wdata = '0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we   = 1'b1;
				ram_addr = clr_ptr_q;
			end
			ST_EXEC: begin
				ram_we    = (item_q.opcode == OP_WRITE) && in_model;
				ram_wdata = item_q.color_index;
			end
			ST_READ: begin
				ram_addr = nbr_addr;
			end
			ST_WB: begin
				ram_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	hvc_ram #(
		.WIDTH (CELL_W),
		.DEPTH (DEPTH)
	) u_grid (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign nz       = (ram_rdata != '0);
	assign hit      = all_q && nz;
	assign out_take = out_valid_q && !out_stall;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= CFG_W'(32);
			size_y_q <= CFG_W'(32);
			size_z_q <= CFG_W'(32);
			cull_q   <= 1'b1;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				REG_SIZE_X: size_x_q <= cfg_data;
				REG_SIZE_Y: size_y_q <= cfg_data;
				REG_SIZE_Z: size_z_q <= cfg_data;
				REG_CULL:   cull_q   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_ptr_q   <= '0;
			nbr_q       <= NBR_FIRST;
			rd_pend_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_pend_s1 <= (state_q == ST_READ);
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_ptr_q <= clr_ptr_q + ADDR_W'(1);
					if (&clr_ptr_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					nbr_q <= NBR_FIRST;
					case (item_q.opcode)
						OP_CLEAR: begin
							clr_ptr_q <= '0;
							state_q   <= ST_CLEAR;
						end
						OP_TEST: state_q <= cand ? ST_READ : ST_DONE;
						default: state_q <= ST_IDLE;
					endcase
				end
				ST_READ: begin
					nbr_q <= nbr_q + NBR_W'(1);
					if (nbr_q == NBR_LAST) begin
						state_q <= ST_LAST;
					end
				end
				ST_LAST: begin
					state_q <= hit ? ST_WB : ST_DONE;
				end
				ST_WB: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_q <= in_item;
		end
		if (state_q == ST_EXEC) begin
			inside_q <= in_model;
			hidden_q <= 1'b0;
			all_q    <= 1'b1;
		end else if (rd_pend_s1) begin
			// fold each returning neighbor into the running AND
			all_q <= all_q & nz;
		end
		if (state_q == ST_LAST) begin
			hidden_q <= hit;
		end
		if (out_load) begin
			out_item_q <= '{out_x: item_q.x_coord, out_y: item_q.y_coord,
				out_z: item_q.z_coord, out_color: item_q.color_index,
				kept: !hidden_q, out_of_range: !inside_q};
		end
	end

endmodule

/* dv/tb_hidden_voxel_cull_top.sv */
module tb_hidden_voxel_cull_top;
	import hvc_pkg::*;

	localparam logic [1:0]        OP_SPARE      = 2'd3;
	localparam logic [CELL_W-1:0] EMPTY_CELL    = '0;
	localparam int                SETTLE_CYCLES = 24;
	localparam int                LONG_HOLD     = 400;
	localparam int                MAX_REPORTS   = 200;

	logic             clk          = 1'b0;
	logic             arst_n       = 1'b0;
	logic             in_valid     = 1'b0;
	logic             in_stall;
	in_item_t         in_item      = '0;
	logic             out_valid;
	logic             out_stall    = 1'b0;
	out_item_t        out_item;
	logic             cfg_write_en = 1'b0;
	logic [IDX_W-1:0] cfg_index    = '0;
	logic [CFG_W-1:0] cfg_data     = '0;

	// requests waiting to be driven, and verdicts waiting to come out
	in_item_t  req_q[$];
	out_item_t verdict_q[$];

	// shadow of the voxel grid and of the model registers
	logic [CELL_W-1:0] grid_model [DEPTH];
	logic [CFG_W-1:0]  dim_x   = 6'd32;
	logic [CFG_W-1:0]  dim_y   = 6'd32;
	logic [CFG_W-1:0]  dim_z   = 6'd32;
	logic              cull_on = 1'b1;

	bit calm      = 1'b0;
	bit req_taken = 1'b0;
	int hold_asks = 0;
	int hold_done = 0;
	int hold_left = 0;
	int rx_burst  = 0;
	int tx_gap    = 0;

	int n_errors   = 0;
	int n_requests = 0;
	int n_results  = 0;
	int n_culled   = 0;
	int n_outside  = 0;
	int n_settings = 0;

	always #1 clk = ~clk;

	hidden_voxel_cull_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_item      (in_item),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_item     (out_item),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	function automatic int clamp_dim(input logic [CFG_W-1:0] s);
		return (int'(s) > MAX_DIM) ? MAX_DIM : int'(s);
	endfunction

	function automatic int cell_index(input int x, input int y, input int z);
		return (x * MAX_DIM + y) * MAX_DIM + z;
	endfunction

	// face neighbor k: k/2 picks the axis, odd k steps up
	function automatic int nbr_step(input int k, input int axis);
		if (k / 2 != axis)
			return 0;
		return (k % 2 == 1) ? 1 : -1;
	endfunction

	function automatic int fill_color();
		return ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 255);
	endfunction

	function automatic int rand_dim();
		return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(3, 8);
	endfunction

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		n_errors++;
		if (n_errors <= MAX_REPORTS)
			$display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
	endtask

	task automatic cull_predict(input in_item_t req);
		int        sx, sy, sz, x, y, z, i;
		bit        in_model, hidden;
		out_item_t res;
		sx = clamp_dim(dim_x);
		sy = clamp_dim(dim_y);
		sz = clamp_dim(dim_z);
		x = int'(req.x_coord);
		y = int'(req.y_coord);
		z = int'(req.z_coord);
		in_model = x < sx && y < sy && z < sz;
		hidden = 1'b0;
		case (req.opcode)
		OP_CLEAR: begin
			for (i = 0; i < DEPTH; i++)
				grid_model[i] = EMPTY_CELL;
		end
		OP_WRITE: begin
			if (in_model)
				grid_model[cell_index(x, y, z)] = req.color_index;
		end
		OP_TEST: begin
			if (in_model && cull_on) begin
				hidden = x > 0 && x + 1 < sx && y > 0 && y + 1 < sy && z > 0 && z + 1 < sz;
				// the tested cell itself is never looked at
				if (hidden)
					hidden = grid_model[cell_index(x - 1, y, z)] != EMPTY_CELL &&
						grid_model[cell_index(x + 1, y, z)] != EMPTY_CELL &&
						grid_model[cell_index(x, y - 1, z)] != EMPTY_CELL &&
						grid_model[cell_index(x, y + 1, z)] != EMPTY_CELL &&
						grid_model[cell_index(x, y, z - 1)] != EMPTY_CELL &&
						grid_model[cell_index(x, y, z + 1)] != EMPTY_CELL;
				if (hidden)
					grid_model[cell_index(x, y, z)] = EMPTY_CELL;
			end
			res.out_x        = req.x_coord;
			res.out_y        = req.y_coord;
			res.out_z        = req.z_coord;
			res.out_color    = req.color_index;
			res.kept         = !hidden;
			res.out_of_range = !in_model;
			verdict_q = {verdict_q, res};
		end
		default: ;
		endcase
	endtask

	task automatic check_verdict(input out_item_t got);
		out_item_t want;
		if (verdict_q.size() == 0) begin
			flag_mismatch("result with nothing pending (out_x)", 32'(got.out_x), 0);
			return;
		end
		want = verdict_q.pop_front();
		if (got.out_x !== want.out_x)
			flag_mismatch("out_x", 32'(got.out_x), 32'(want.out_x));
		if (got.out_y !== want.out_y)
			flag_mismatch("out_y", 32'(got.out_y), 32'(want.out_y));
		if (got.out_z !== want.out_z)
			flag_mismatch("out_z", 32'(got.out_z), 32'(want.out_z));
		if (got.out_color !== want.out_color)
			flag_mismatch("out_color", 32'(got.out_color), 32'(want.out_color));
		if (got.kept !== want.kept)
			flag_mismatch("kept", 32'(got.kept), 32'(want.kept));
		if (got.out_of_range !== want.out_of_range)
			flag_mismatch("out_of_range", 32'(got.out_of_range), 32'(want.out_of_range));
	endtask

	task automatic push_req(input logic [1:0] op, input int x, input int y, input int z,
			input int c);
		in_item_t r;
		r.opcode      = op;
		r.x_coord     = COORD_W'(x);
		r.y_coord     = COORD_W'(y);
		r.z_coord     = COORD_W'(z);
		r.color_index = CELL_W'(c);
		req_q = {req_q, r};
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input int val);
		@(negedge clk);
		cfg_write_en <= 1'b1;
		cfg_index    <= idx;
		cfg_data     <= CFG_W'(val);
		case (idx)
		REG_SIZE_X: dim_x = CFG_W'(val);
		REG_SIZE_Y: dim_y = CFG_W'(val);
		REG_SIZE_Z: dim_z = CFG_W'(val);
		REG_CULL:   cull_on = val[0];
		default: ;
		endcase
	endtask

	task automatic set_model(input int sx, input int sy, input int sz, input bit ce);
		write_reg(REG_SIZE_X, sx);
		write_reg(REG_SIZE_Y, sy);
		write_reg(REG_SIZE_Z, sz);
		write_reg(REG_CULL, ce);
		@(negedge clk);
		cfg_write_en <= 1'b0;
		n_settings++;
	endtask

	// wait for every verdict, then let the grid port go quiet
	task automatic drain();
		while (req_q.size() != 0 || verdict_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// mostly filled neighborhoods around a tested voxel, the rest scattered noise
	task automatic queue_phase(input int n, input bit with_clear);
		int         ex, ey, ez, made, cx, cy, cz, k;
		logic [1:0] op;
		ex = clamp_dim(dim_x);
		ey = clamp_dim(dim_y);
		ez = clamp_dim(dim_z);
		made = 0;
		if (with_clear)
			push_req(OP_CLEAR, $urandom_range(0, 255), $urandom_range(0, 255),
				$urandom_range(0, 255), $urandom_range(0, 255));
		while (made < n) begin
			if ($urandom_range(0, 9) < 6 && ex > 2 && ey > 2 && ez > 2) begin
				cx = $urandom_range(1, ex - 2);
				cy = $urandom_range(1, ey - 2);
				cz = $urandom_range(1, ez - 2);
				for (k = 0; k < 6; k++) begin
					if ($urandom_range(0, 7) != 0) begin
						push_req(OP_WRITE, cx + nbr_step(k, 0), cy + nbr_step(k, 1),
							cz + nbr_step(k, 2), fill_color());
						made++;
					end
				end
				if ($urandom_range(0, 1) == 1) begin
					push_req(OP_WRITE, cx, cy, cz, fill_color());
					made++;
				end
				push_req(OP_TEST, cx, cy, cz, $urandom_range(0, 255));
				made++;
			end else begin
				k = $urandom_range(0, 9);
				op = (k < 5) ? OP_WRITE : ((k < 9) ? OP_TEST : OP_SPARE);
				if ($urandom_range(0, 3) == 0)
					push_req(op, $urandom_range(0, 255), $urandom_range(0, 255),
						$urandom_range(0, 255), $urandom_range(0, 255));
				else
					push_req(op, $urandom_range(0, ex), $urandom_range(0, ey),
						$urandom_range(0, ez), $urandom_range(0, 255));
				if (op != OP_SPARE)
					made++;
			end
		end
		// close with a test so the phase ends on a verdict
		push_req(OP_TEST, $urandom_range(0, ex), $urandom_range(0, ey), $urandom_range(0, ez),
			$urandom_range(0, 255));
	endtask

	// request driver
	always @(negedge clk) begin
		if (!in_valid || req_taken) begin
			if (tx_gap > 0) begin
				in_valid <= 1'b0;
				tx_gap--;
			end else if (req_q.size() == 0) begin
				in_valid <= 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				in_valid <= 1'b0;
				tx_gap = $urandom_range(0, 8);
			end else begin
				in_valid <= 1'b1;
				in_item  <= req_q[0];
			end
		end
	end

	// result receiver
	always @(negedge clk) begin
		if (hold_done != hold_asks) begin
			hold_done = hold_asks;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (rx_burst > 0) begin
			out_stall <= 1'b1;
			rx_burst--;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			out_stall <= 1'b1;
			rx_burst = $urandom_range(0, 8);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// monitor: check the verdict leaving, then predict the request entering
	always @(posedge clk) begin
		req_taken = arst_n && in_valid && !in_stall;
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			if (!out_item.kept)
				n_culled++;
			if (out_item.out_of_range)
				n_outside++;
			check_verdict(out_item);
		end
		if (req_taken) begin
			cull_predict(in_item);
			req_q.delete(0);
			n_requests++;
		end
	end

	initial begin
		int i, k;
		for (i = 0; i < DEPTH; i++)
			grid_model[i] = EMPTY_CELL;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// two adjacent candidates A (5,6,7) and B (6,6,7), fully surrounded
		push_req(OP_WRITE, 5, 6, 7, 8'h11);
		push_req(OP_WRITE, 6, 6, 7, 8'h22);
		for (k = 0; k < 6; k++) begin
			if (k != 1)
				push_req(OP_WRITE, 5 + nbr_step(k, 0), 6 + nbr_step(k, 1), 7 + nbr_step(k, 2),
					8'h80 + k);
			if (k != 0)
				push_req(OP_WRITE, 6 + nbr_step(k, 0), 6 + nbr_step(k, 1), 7 + nbr_step(k, 2),
					8'hF0 + k);
		end
		push_req(OP_TEST, 5, 6, 7, 8'h11);         // A hidden and removed
		push_req(OP_TEST, 6, 6, 7, 8'h22);         // B now sees an empty A
		push_req(OP_TEST, 5, 6, 7, 8'h33);         // A empty itself, still hidden
		push_req(OP_WRITE, 4, 6, 7, 8'h00);        // punch a hole next to A
		push_req(OP_TEST, 5, 6, 7, 8'h44);
		push_req(OP_TEST, 0, 0, 0, 8'hFF);
		push_req(OP_TEST, 31, 31, 31, 8'h00);
		push_req(OP_TEST, 255, 255, 255, 8'hAA);
		push_req(OP_TEST, 32, 0, 0, 8'h55);
		push_req(OP_WRITE, 40, 1, 1, 8'hFF);       // drop: outside the model
		push_req(OP_SPARE, 6, 6, 7, 8'h01);
		push_req(OP_CLEAR, 0, 0, 0, 0);
		push_req(OP_TEST, 6, 6, 7, 8'h22);
		drain();

		// oversized extents with culling off; receiver holds off long enough to back up
		set_model(63, 63, 63, 1'b0);
		hold_asks++;
		queue_phase(100, 1'b0);
		drain();

		set_model(4, 4, 4, 1'b1);
		queue_phase(130, 1'b1);
		drain();

		set_model(1, 1, 1, 1'b1);
		queue_phase(40, 1'b0);
		drain();

		set_model(0, 5, 3, 1'b1);
		queue_phase(40, 1'b0);
		drain();

		for (i = 0; i < 4; i++) begin
			set_model(rand_dim(), rand_dim(), rand_dim(), $urandom_range(0, 4) != 0);
			queue_phase(90, $urandom_range(0, 1) == 1);
			drain();
		end

		// no idling from here on
		calm = 1'b1;
		set_model(32, 32, 32, 1'b1);
		queue_phase(120, 1'b1);
		drain();

		$display("Covered %0d requests over %0d model settings: %0d verdicts checked",
			n_requests, n_settings + 1, n_results);
		$display("  %0d culled, %0d out of range, %0d field mismatches",
			n_culled, n_outside, n_errors);
		if (n_errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#4000000;
		$display("Timed out: %0d requests unsent, %0d verdicts pending",
			req_q.size(), verdict_q.size());
		$display("Regression FAIL");
		$finish;
	end

endmodule

/* sim.f */
src/hvc_pkg.sv
src/hvc_ram.sv
src/hvc_nbr_unit.sv
src/hidden_voxel_cull_top.sv
dv/tb_hidden_voxel_cull_top.sv
